>>> design/sdf_pkg.sv
`default_nettype none
package sdf_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DIGITS  = 19;
  localparam int unsigned BCD_W   = DIGITS * 4;
  localparam int unsigned POS_W   = $clog2(DIGITS);
  localparam int unsigned CAP_W   = 6;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned STEP_W  = $clog2(VALUE_W);

  localparam logic [CAP_W-1:0]  CAP_RESET  = 6'd22;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [STEP_W-1:0] STEP_LAST  = '1;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic             neg;
    logic [POS_W-1:0] top;
    bcd_t             digits;
  } entry_t;

endpackage
`default_nettype wire

>>> design/sdf_front.sv
`default_nettype none
module sdf_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [sdf_pkg::VALUE_W-1:0]  in_tdata,
  output logic                         push_valid,
  input  wire                          push_ready,
  output sdf_pkg::entry_t              push_data
);
  import sdf_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } fstate_t;

  fstate_t             state_r;
  logic [VALUE_W-1:0]  mag_r;
  logic                neg_r;
  logic [BCD_W-1:0]    bcd_r;
  logic [STEP_W-1:0]   step_r;

  logic [BCD_W-1:0]    adj;
  logic [BCD_W-1:0]    bcd_nxt;
  logic [POS_W-1:0]    top;

  // shift-add-3 step
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
    bcd_nxt = {adj[BCD_W-2:0], mag_r[VALUE_W-1]};
  end

  // highest nonzero digit
  always_comb begin
    top = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        top = POS_W'(i);
      end
    end
  end

  assign in_tready        = (state_r == F_IDLE);
  assign push_valid       = (state_r == F_PUSH);
  assign push_data.neg    = neg_r;
  assign push_data.top    = top;
  assign push_data.digits = bcd_t'(bcd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_tvalid) begin
            neg_r   <= in_tdata[VALUE_W-1];
            mag_r   <= in_tdata[VALUE_W-1] ? (~in_tdata + VALUE_W'(1)) : in_tdata;
            bcd_r   <= '0;
            step_r  <= STEP_LAST;
            state_r <= F_CONV;
          end
        end
        F_CONV: begin
          bcd_r  <= bcd_nxt;
          mag_r  <= {mag_r[VALUE_W-2:0], 1'b0};
          step_r <= step_r - STEP_W'(1);
          if (step_r == '0) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

  a_conv_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == F_CONV && step_r == STEP_LAST)
    else $error("conversion did not start after request");

endmodule
`default_nettype wire

>>> design/sdf_queue.sv
`default_nettype none
module sdf_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  sdf_pkg::entry_t  push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output sdf_pkg::entry_t  pop_data
);
  import sdf_pkg::*;

  entry_t      mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/sdf_back.sv
`default_nettype none
module sdf_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire  [sdf_pkg::CAP_W-1:0]   cfg_wdata,
  input  wire                         pop_valid,
  output logic                        pop_ready,
  input  sdf_pkg::entry_t             pop_data,
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [sdf_pkg::CHAR_W-1:0]  out_tdata,
  output logic                        out_tuser,
  output logic                        out_tlast
);
  import sdf_pkg::*;

  logic [CAP_W-1:0]   cap_r;
  logic               cur_v_r;
  logic               cur_empty_r;
  logic               cur_neg_r;
  logic [POS_W-1:0]   cur_pos_r;
  bcd_t               cur_dig_r;
  logic               out_v_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_empty_r;
  logic               out_last_r;

  logic [CAP_W-1:0]   total;
  logic               no_fit;
  logic               adv;
  logic [CHAR_W-1:0]  gen_char;
  logic               gen_last;

  assign total  = CAP_W'(pop_data.top) + CAP_W'(1) + CAP_W'(pop_data.neg);
  assign no_fit = (total >= cap_r);
  assign pop_ready = !cur_v_r;
  assign adv    = cur_v_r && (!out_v_r || out_tready);

  always_comb begin
    if (cur_empty_r) begin
      gen_char = '0;
      gen_last = 1'b1;
    end else if (cur_neg_r) begin
      gen_char = CHAR_MINUS;
      gen_last = 1'b0;
    end else begin
      gen_char = CHAR_ZERO + CHAR_W'(cur_dig_r[cur_pos_r]);
      gen_last = (cur_pos_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!cur_v_r && pop_valid) begin
        cur_v_r     <= 1'b1;
        cur_empty_r <= no_fit;
        cur_neg_r   <= pop_data.neg;
        cur_pos_r   <= pop_data.top;
        cur_dig_r   <= pop_data.digits;
      end else if (adv) begin
        if (cur_empty_r) begin
          cur_v_r <= 1'b0;
        end else if (cur_neg_r) begin
          cur_neg_r <= 1'b0;
        end else if (cur_pos_r == '0) begin
          cur_v_r <= 1'b0;
        end else begin
          cur_pos_r <= cur_pos_r - POS_W'(1);
        end
      end
      if (adv) begin
        out_v_r     <= 1'b1;
        out_char_r  <= gen_char;
        out_empty_r <= cur_empty_r;
        out_last_r  <= gen_last;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_empty_r;
  assign out_tlast  = out_last_r;

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_empty_r |-> out_last_r && out_char_r == '0)
    else $error("empty result malformed");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_empty_r |->
      out_char_r == CHAR_MINUS || (out_char_r >= CHAR_ZERO && out_char_r <= CHAR_NINE))
    else $error("character outside sign and digits");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_empty_r && out_char_r == CHAR_MINUS |-> !out_last_r)
    else $error("sign marked as last");

endmodule
`default_nettype wire

>>> design/signed_decimal_formatter_core.sv
`default_nettype none
// from request to first character: 64 shift-add-3 steps, queue push and back-end load,
// then one character per cycle while out_tready is high
// the front end takes no new value until its 64-step bit-serial bcd converter has
// pushed the last one; the two-entry queue lets the front convert while the back emits
// reset: synchronous active-low rst_n empties pipeline and queue, capacity returns to 22
module signed_decimal_formatter_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire  [sdf_pkg::CAP_W-1:0]   cfg_wdata,   // buffer_capacity
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire  [sdf_pkg::VALUE_W-1:0] in_tdata,    // value
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [sdf_pkg::CHAR_W-1:0]  out_tdata,   // character
  output logic                        out_tuser,   // empty_res
  output logic                        out_tlast
);
  import sdf_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  sdf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb;
  import sdf_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              empty;
    logic              fin;
  } text_char_t;

  class decimal_scoreboard;
    logic [CAP_W-1:0] capacity;
    text_char_t       expected_chars[$];
    int               errors;

    function new();
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(input logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int outstanding();
      return expected_chars.size();
    endfunction

    // render one value as decimal text under the current capacity
    function void note_value(input logic [VALUE_W-1:0] v);
      logic              neg;
      logic [63:0]       mag;
      logic [CHAR_W-1:0] digs[20];
      int                n;
      int                total;
      text_char_t        c;
      neg = v[63];
      mag = neg ? (~v + 64'd1) : v;
      n = 0;
      do begin
        digs[n] = CHAR_ZERO + 8'(mag % 64'd10);
        n++;
        mag = mag / 64'd10;
      end while (mag != 64'd0 && n < 20);
      total = n + (neg ? 1 : 0);
      if (total >= int'(capacity)) begin
        c.ch = '0;
        c.empty = 1'b1;
        c.fin = 1'b1;
        expected_chars.push_back(c);
        return;
      end
      if (neg) begin
        c.ch = CHAR_MINUS;
        c.empty = 1'b0;
        c.fin = 1'b0;
        expected_chars.push_back(c);
      end
      while (n > 0) begin
        n--;
        c.ch = digs[n];
        c.empty = 1'b0;
        c.fin = (n == 0);
        expected_chars.push_back(c);
      end
    endfunction

    task report(input string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_char(input logic [CHAR_W-1:0] ch, input logic empty, input logic fin);
      text_char_t e;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected character %h empty %b last %b", ch, empty, fin));
        return;
      end
      e = expected_chars.pop_front();
      if (ch !== e.ch || empty !== e.empty || fin !== e.fin)
        report($sformatf("got char %h empty %b last %b, expected %h %b %b",
                         ch, empty, fin, e.ch, e.empty, e.fin));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [VALUE_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [CHAR_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  decimal_scoreboard sb = new();
  bit in_idle;
  bit out_idle;
  int out_stall;

  signed_decimal_formatter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [63:0] mag;
    int k;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return {$urandom, $urandom};
    if (sel == 1) begin
      case ($urandom_range(0, 3))
        0: return 64'd0;
        1: return 64'h7FFF_FFFF_FFFF_FFFF;
        2: return 64'h8000_0000_0000_0000;
        default: return '1;
      endcase
    end
    k = $urandom_range(1, 19);
    if (k == 19) begin
      mag = 64'd1000000000000000000 + ({$urandom, $urandom} % 64'd8223372036854775807);
    end else begin
      mag = $urandom_range(1, 9);
      repeat (k - 1) mag = mag * 64'd10 + 64'($urandom_range(0, 9));
    end
    return $urandom_range(0, 1) ? (~mag + 64'd1) : mag;
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] v);
    int g;
    @(negedge clk);
    g = (in_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (g > 0) begin
      in_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = v;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_value(v);
  endtask

  // hold off new requests until the block has emitted everything
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = c;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_capacity(c);
  endtask

  initial begin
    out_tready = 1'b0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (out_stall > 0) begin
        out_tready = 1'b0;
        out_stall--;
      end else begin
        out_tready = 1'b1;
        if (out_idle && $urandom_range(0, 3) == 0) out_stall = pick_gap();
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
        sb.check_char(out_tdata, out_tuser, out_tlast);
    end
  end

  initial begin
    #(12 * 1200000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0] caps[12];
    logic [VALUE_W-1:0] directed[$];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_idle = 1'b0;
    out_idle = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset capacity: extremes of the value, digit-count boundaries
    directed = '{64'd0, 64'd1, '1, 64'd9, -64'sd9, 64'd10, -64'sd10,
                 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'h8000_0000_0000_0001, 64'd999999999999999999,
                 64'd1000000000000000000, -64'sd1000000000000000000,
                 -64'sd999999999999999999, 64'd12345678, 64'hFFFF_FFFF,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
    foreach (directed[i]) send_value(directed[i]);
    drain();

    // capacity boundaries: tiny, one below and at the longest text, above range
    caps = '{6'd0, 6'd1, 6'd2, 6'd20, 6'd21, 6'd19, 6'd32, 6'd63,
             6'd8, 6'd22, 6'($urandom_range(0, 63)), 6'($urandom_range(3, 21))};
    for (int p = 0; p < 12; p++) begin
      write_capacity(caps[p]);
      in_idle = (p % 3 != 0);
      out_idle = (p % 4 != 1);
      repeat (30) send_value(random_value());
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d characters never emitted", sb.outstanding()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
